// ----- rtl/core/iirdf1_pkg.sv -----
// Shared types, constants and coefficient tables for the direct form I IIR filter.
package iirdf1_pkg;

    localparam int COEF_W    = 24;
    localparam int COEF_FRAC = 22;
    localparam int OUT_W     = 24;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FF,
        ST_FB,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SRC_X,
        SRC_IN,
        SRC_OUT
    } src_t;

    typedef struct packed {
        logic clear;
        logic en;
        logic sub;
    } mac_ctrl_t;

    // Feedforward coefficients b[i], Q2.22; zero past the table.
    function automatic logic signed [COEF_W-1:0] ff_coef(input int idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            0:       c = 24'sd0;
            1:       c = 24'sd419430;
            2:       c = 24'sd838861;
            3:       c = 24'sd1258291;
            4:       c = 24'sd1677722;
            5:       c = 24'sd2097152;
            6:       c = 24'sd2516582;
            7:       c = 24'sd2936013;
            8:       c = 24'sd3355443;
            9:       c = 24'sd3774874;
            10:      c = 24'sd4194304;
            11:      c = 24'sd3774874;
            12:      c = 24'sd3355443;
            13:      c = 24'sd2936013;
            14:      c = 24'sd2516582;
            15:      c = 24'sd2097152;
            16:      c = 24'sd1677722;
            17:      c = 24'sd1258291;
            18:      c = 24'sd838861;
            19:      c = 24'sd419430;
            default: c = 24'sd0;
        endcase
        return c;
    endfunction

    // Feedback coefficients a[j], Q2.22; zero past the table.
    function automatic logic signed [COEF_W-1:0] fb_coef(input int idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            0:       c = 24'sd0;
            1:       c = 24'sd419;
            2:       c = 24'sd839;
            3:       c = 24'sd1258;
            4:       c = 24'sd1678;
            5:       c = 24'sd2097;
            6:       c = 24'sd2517;
            7:       c = 24'sd2936;
            8:       c = 24'sd3355;
            9:       c = 24'sd3775;
            10:      c = 24'sd4194;
            default: c = 24'sd0;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/iir_filter_direct_form_one.sv -----
// Top level of the direct form I IIR filter: sequencer, history memories and MAC.
//
//  channel  | valid     | ready     | payload
//  ---------+-----------+-----------+-------------------------------------
//  input    | in_valid  | in_ready  | sample_in (SAMPLE_BITS, signed Q1.15)
//  output   | out_valid | out_ready | sample_out (24, signed Q9.15), saturated
//
// Each sample is processed as one MAC step per tap, fed by one history memory read
// per cycle, after the accept and followed by the memory read register, the product
// register, a drain state and the final writeback.
// Reset empties both histories through fill counts; unfilled entries count as zero.
// A new sample is taken while the previous result waits in the output register;
// writeback stalls only if that register is still occupied.
module iir_filter_direct_form_one #(
    parameter int FEEDFORWARD_TAPS = 20,
    parameter int FEEDBACK_TAPS    = 10,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [SAMPLE_BITS-1:0]        sample_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [iirdf1_pkg::OUT_W-1:0]  sample_out,
    output logic                                 saturated
);
    import iirdf1_pkg::*;

    // History geometry. The input history holds FEEDFORWARD_TAPS-1 samples;
    // with a single feedforward tap it is never written.
    localparam int IN_D   = (FEEDFORWARD_TAPS > 1) ? FEEDFORWARD_TAPS - 1 : 1;
    localparam int IN_AW  = (IN_D > 1) ? $clog2(IN_D) : 1;
    localparam int IN_FW  = $clog2(IN_D + 1);
    localparam int OUT_D  = FEEDBACK_TAPS;
    localparam int OUT_AW = (OUT_D > 1) ? $clog2(OUT_D) : 1;
    localparam int OUT_FW = $clog2(OUT_D + 1);
    localparam int MAXT   = (FEEDFORWARD_TAPS > FEEDBACK_TAPS) ? FEEDFORWARD_TAPS
                                                               : FEEDBACK_TAPS;
    localparam int CNT_W  = (MAXT > 1) ? $clog2(MAXT) : 1;
    localparam int OP_W   = (SAMPLE_BITS > OUT_W) ? SAMPLE_BITS : OUT_W;
    localparam int ACC_W  = OP_W + COEF_W + $clog2(FEEDFORWARD_TAPS + FEEDBACK_TAPS + 1);
    localparam logic IN_HIST_ON = (FEEDFORWARD_TAPS > 1);

    // Sequencer state
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         tap_reg, tap_next;
    logic                     drain_reg, drain_next;
    logic signed [SAMPLE_BITS-1:0] x_reg, x_next;

    // Ring pointers and fill counts
    logic [IN_AW-1:0]         in_wptr_reg, in_wptr_next;
    logic [IN_AW-1:0]         in_rptr_reg, in_rptr_next;
    logic [IN_FW-1:0]         in_fill_reg, in_fill_next;
    logic [IN_FW-1:0]         in_left_reg, in_left_next;
    logic [OUT_AW-1:0]        out_wptr_reg, out_wptr_next;
    logic [OUT_AW-1:0]        out_rptr_reg, out_rptr_next;
    logic [OUT_FW-1:0]        out_fill_reg, out_fill_next;
    logic [OUT_FW-1:0]        out_left_reg, out_left_next;

    // Stage aligned with memory read data
    logic                     s1_valid_reg, s1_valid_next;
    src_t                     s1_src_reg, s1_src_next;
    logic                     s1_live_reg, s1_live_next;
    logic                     s1_sub_reg, s1_sub_next;
    logic signed [COEF_W-1:0] s1_coef_reg, s1_coef_next;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]  sample_out_reg, sample_out_next;
    logic                     sat_reg, sat_next;

    // Memory ports
    logic                     in_rd_en, in_wr_en;
    logic                     out_rd_en, out_wr_en;
    logic [SAMPLE_BITS-1:0]   in_rd_data;
    logic [OUT_W-1:0]         out_rd_data;

    // MAC
    mac_ctrl_t                mac_ctrl;
    logic signed [OP_W-1:0]   mac_op;
    logic signed [OUT_W-1:0]  mac_y;
    logic                     mac_sat;

    logic                     in_xfer;
    logic                     wb_go;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign wb_go    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Sequencer: one tap issued per cycle, feedforward first, then feedback.
    always_comb
    begin
        state_next      = state_reg;
        tap_next        = tap_reg;
        drain_next      = drain_reg;
        x_next          = x_reg;
        in_wptr_next    = in_wptr_reg;
        in_rptr_next    = in_rptr_reg;
        in_fill_next    = in_fill_reg;
        in_left_next    = in_left_reg;
        out_wptr_next   = out_wptr_reg;
        out_rptr_next   = out_rptr_reg;
        out_fill_next   = out_fill_reg;
        out_left_next   = out_left_reg;
        s1_valid_next   = 1'b0;
        s1_src_next     = s1_src_reg;
        s1_live_next    = s1_live_reg;
        s1_sub_next     = s1_sub_reg;
        s1_coef_next    = s1_coef_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        sample_out_next = sample_out_reg;
        sat_next        = sat_reg;
        in_rd_en        = 1'b0;
        out_rd_en       = 1'b0;
        in_wr_en        = 1'b0;
        out_wr_en       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    x_next        = sample_in;
                    tap_next      = '0;
                    // newest entry sits just behind the write pointer
                    in_rptr_next  = (in_wptr_reg == '0) ? IN_AW'(IN_D - 1)
                                                        : in_wptr_reg - 1'b1;
                    out_rptr_next = (out_wptr_reg == '0) ? OUT_AW'(OUT_D - 1)
                                                         : out_wptr_reg - 1'b1;
                    in_left_next  = in_fill_reg;
                    out_left_next = out_fill_reg;
                    state_next    = ST_FF;
                end
            end

            ST_FF:
            begin
                s1_valid_next = 1'b1;
                s1_sub_next   = 1'b0;
                s1_coef_next  = ff_coef(int'(tap_reg));
                if (tap_reg == '0)
                begin
                    s1_src_next  = SRC_X;
                    s1_live_next = 1'b1;
                end
                else
                begin
                    s1_src_next  = SRC_IN;
                    s1_live_next = (in_left_reg != '0);
                    in_rd_en     = 1'b1;
                    in_rptr_next = (in_rptr_reg == '0) ? IN_AW'(IN_D - 1)
                                                       : in_rptr_reg - 1'b1;
                    if (in_left_reg != '0)
                    begin
                        in_left_next = in_left_reg - 1'b1;
                    end
                end
                if (tap_reg == CNT_W'(FEEDFORWARD_TAPS - 1))
                begin
                    tap_next   = '0;
                    state_next = ST_FB;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end

            ST_FB:
            begin
                s1_valid_next = 1'b1;
                s1_sub_next   = 1'b1;
                s1_coef_next  = fb_coef(int'(tap_reg) + 1);
                s1_src_next   = SRC_OUT;
                s1_live_next  = (out_left_reg != '0);
                out_rd_en     = 1'b1;
                out_rptr_next = (out_rptr_reg == '0) ? OUT_AW'(OUT_D - 1)
                                                     : out_rptr_reg - 1'b1;
                if (out_left_reg != '0)
                begin
                    out_left_next = out_left_reg - 1'b1;
                end
                if (tap_reg == CNT_W'(FEEDBACK_TAPS - 1))
                begin
                    tap_next   = '0;
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    tap_next = tap_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                // wait for the read stage and product register to empty
                drain_next = 1'b1;
                if (drain_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (wb_go)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = mac_y;
                    sat_next        = mac_sat;
                    out_wr_en       = 1'b1;
                    out_wptr_next   = (out_wptr_reg == OUT_AW'(OUT_D - 1)) ? '0
                                                     : out_wptr_reg + 1'b1;
                    if (out_fill_reg != OUT_FW'(OUT_D))
                    begin
                        out_fill_next = out_fill_reg + 1'b1;
                    end
                    if (IN_HIST_ON)
                    begin
                        in_wr_en     = 1'b1;
                        in_wptr_next = (in_wptr_reg == IN_AW'(IN_D - 1)) ? '0
                                                       : in_wptr_reg + 1'b1;
                        if (in_fill_reg != IN_FW'(IN_D))
                        begin
                            in_fill_next = in_fill_reg + 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tap_reg       <= '0;
            drain_reg     <= 1'b0;
            in_wptr_reg   <= '0;
            in_rptr_reg   <= '0;
            in_fill_reg   <= '0;
            in_left_reg   <= '0;
            out_wptr_reg  <= '0;
            out_rptr_reg  <= '0;
            out_fill_reg  <= '0;
            out_left_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tap_reg       <= tap_next;
            drain_reg     <= drain_next;
            in_wptr_reg   <= in_wptr_next;
            in_rptr_reg   <= in_rptr_next;
            in_fill_reg   <= in_fill_next;
            in_left_reg   <= in_left_next;
            out_wptr_reg  <= out_wptr_next;
            out_rptr_reg  <= out_rptr_next;
            out_fill_reg  <= out_fill_next;
            out_left_reg  <= out_left_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        s1_src_reg     <= s1_src_next;
        s1_live_reg    <= s1_live_next;
        s1_sub_reg     <= s1_sub_next;
        s1_coef_reg    <= s1_coef_next;
        sample_out_reg <= sample_out_next;
        sat_reg        <= sat_next;
    end

    // Operand select; unfilled history entries contribute zero.
    always_comb
    begin
        mac_op = '0;
        if (s1_live_reg)
        begin
            case (s1_src_reg)
                SRC_X:   mac_op = OP_W'(x_reg);
                SRC_IN:  mac_op = OP_W'(signed'(in_rd_data));
                SRC_OUT: mac_op = OP_W'(signed'(out_rd_data));
                default: mac_op = '0;
            endcase
        end
    end

    assign mac_ctrl.clear = in_xfer;
    assign mac_ctrl.en    = s1_valid_reg;
    assign mac_ctrl.sub   = s1_sub_reg;

    iirdf1_hist #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (IN_D),
        .AW    (IN_AW)
    ) u_in_hist (
        .clk     (clk),
        .wr_en   (in_wr_en),
        .wr_addr (in_wptr_reg),
        .wr_data (x_reg),
        .rd_en   (in_rd_en),
        .rd_addr (in_rptr_reg),
        .rd_data (in_rd_data)
    );

    iirdf1_hist #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_D),
        .AW    (OUT_AW)
    ) u_out_hist (
        .clk     (clk),
        .wr_en   (out_wr_en),
        .wr_addr (out_wptr_reg),
        .wr_data (mac_y),
        .rd_en   (out_rd_en),
        .rd_addr (out_rptr_reg),
        .rd_data (out_rd_data)
    );

    iirdf1_mac #(
        .OP_W  (OP_W),
        .ACC_W (ACC_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .op    (mac_op),
        .coef  (s1_coef_reg),
        .y     (mac_y),
        .sat   (mac_sat)
    );

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = sat_reg;

`ifndef SYNTH
    // A new result appears only from a writeback.
    a_out_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result shown without writeback");

    // Read stage feeding the MAC is empty by the time the result is taken.
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !s1_valid_reg)
        else $error("writeback before MAC pipeline drained");

    // Accumulator clear never collides with a product in flight.
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> !s1_valid_reg)
        else $error("accumulator cleared during accumulation");

    // Fill counts stay within the history depths.
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fill_reg <= IN_FW'(IN_D)) && (out_fill_reg <= OUT_FW'(OUT_D)))
        else $error("history fill count out of range");
`endif

endmodule

// ----- rtl/core/iirdf1_hist.sv -----
// History ring memory: one write port, one read port with registered read data.
module iirdf1_hist #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 19,
    parameter int AW    = 5
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] ram [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ram[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/iirdf1_mac.sv -----
// Multiply-accumulate unit with round-half-up and saturation to Q9.15.
module iirdf1_mac #(
    parameter int OP_W  = 24,
    parameter int ACC_W = 53
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  iirdf1_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [OP_W-1:0]                op,
    input  logic signed [iirdf1_pkg::COEF_W-1:0]  coef,
    output logic signed [iirdf1_pkg::OUT_W-1:0]   y,
    output logic                                  sat
);
    import iirdf1_pkg::*;

    localparam int PROD_W = OP_W + COEF_W;
    localparam int RND_W  = ACC_W + 1;
    localparam int YB_W   = RND_W - COEF_FRAC;
    localparam logic [RND_W-1:0] ROUND_HALF = RND_W'(1) << (COEF_FRAC - 1);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic                     en_d_reg;
    logic                     sub_d_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [RND_W-1:0]  rnd;
    logic [YB_W-1:0]          ybig;
    logic [YB_W-OUT_W:0]      upper;
    logic                     fits;

    assign prod_next = op * coef;
    assign prod_ext  = ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (en_d_reg)
        begin
            acc_next = sub_d_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_d_reg  <= 1'b0;
            sub_d_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            en_d_reg  <= ctrl.en;
            sub_d_reg <= ctrl.sub;
            acc_reg   <= acc_next;
        end
    end

    // Round half up at bit COEF_FRAC, then clip to the output range.
    assign rnd   = RND_W'(acc_reg) + ROUND_HALF;
    assign ybig  = rnd[RND_W-1:COEF_FRAC];
    assign upper = ybig[YB_W-1:OUT_W-1];
    assign fits  = (&upper) || !(|upper);
    assign sat   = !fits;

    always_comb
    begin
        if (fits)
        begin
            y = ybig[OUT_W-1:0];
        end
        else if (ybig[YB_W-1])
        begin
            y = OUT_MIN;
        end
        else
        begin
            y = OUT_MAX;
        end
    end

endmodule
